@@ hw/rtl/erfb_pkg.sv @@
// Package: types, codes and constants shared by the frame builder modules.
`default_nettype none

package erfb_pkg;

   localparam logic       OpStart       = 1'b0;
   localparam logic       OpData        = 1'b1;

   localparam logic [7:0] EscMark       = 8'hFE;
   localparam logic [7:0] EscFf         = 8'hFD;
   localparam logic [7:0] EscFe         = 8'hFC;
   localparam logic [7:0] RawFf         = 8'hFF;
   localparam logic [7:0] RawFe         = 8'hFE;
   localparam logic [7:0] FrameLenExtra = 8'd4;

   localparam int         SlotCount     = 6;
   localparam int         SlotIdxW      = $clog2(SlotCount);
   localparam int         QueueDepth    = 2;

   typedef struct packed {
      logic       opcode;
      logic [15:0] dest_address;
      logic [7:0] source_port;
      logic [7:0] dest_port;
      logic [7:0] payload_length;
      logic [7:0] payload_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       frame_end;
   } rsp_type;

   // One item's worth of output: packed slots, each escaped or sent raw.
   typedef struct packed {
      logic [SlotCount-1:0][7:0] slot_byte;
      logic [SlotCount-1:0]      slot_esc;
      logic [SlotIdxW-1:0]       slot_count;
      logic                      frame_end;
   } job_type;

   function automatic logic needs_escape(input logic [7:0] b);
      return (b == RawFf) || (b == RawFe);
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/erfb_front.sv @@
// Front end: accepts items, tracks the open frame and builds output jobs.
`default_nettype none

module erfb_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire erfb_pkg::req_type req_data,
   input  wire logic             queue_full,
   output logic                  push,
   output erfb_pkg::job_type     push_job
);
   import erfb_pkg::*;

   logic [7:0] bytes_left_ff, bytes_left_in;
   logic       frame_open_ff, frame_open_in;
   logic       tail_valid_ff, tail_valid_in;
   logic [7:0] tail_byte_ff,  tail_byte_in;

   logic       accept;
   logic [7:0] addr_hi;
   logic [7:0] addr_lo;
   logic       defer_lo;
   logic       has_payload;
   logic [7:0] left_next;
   job_type    job;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign addr_hi   = req_data.dest_address[15:8];
   assign addr_lo   = req_data.dest_address[7:0];
   assign defer_lo  = needs_escape(addr_hi) || needs_escape(addr_lo);
   assign has_payload = (bytes_left_ff != 8'd0);
   assign left_next = has_payload ? (bytes_left_ff - 8'd1) : bytes_left_ff;

   always_comb begin
      job            = '0;
      bytes_left_in  = bytes_left_ff;
      frame_open_in  = frame_open_ff;
      tail_valid_in  = tail_valid_ff;
      tail_byte_in   = tail_byte_ff;
      unique case (req_data.opcode)
         OpStart: begin
            job.slot_byte[0] = EscMark;
            job.slot_byte[1] = req_data.payload_length + FrameLenExtra;
            job.slot_byte[2] = req_data.source_port;
            job.slot_byte[3] = req_data.dest_port;
            job.slot_byte[4] = addr_hi;
            job.slot_byte[5] = addr_lo;
            job.slot_esc     = 6'b110000;
            job.slot_count   = defer_lo ? SlotIdxW'(5) : SlotIdxW'(6);
            job.frame_end    = (req_data.payload_length == 8'd0) && !defer_lo;
            bytes_left_in    = req_data.payload_length;
            frame_open_in    = !job.frame_end;
            tail_valid_in    = defer_lo;
            tail_byte_in     = addr_lo;
         end
         OpData: begin
            if (frame_open_ff) begin
               // Deferred address low byte goes ahead of the payload byte.
               job.slot_byte[0] = tail_valid_ff ? tail_byte_ff : req_data.payload_byte;
               job.slot_byte[1] = req_data.payload_byte;
               job.slot_esc     = 6'b000011;
               job.slot_count   = SlotIdxW'({2'b00, tail_valid_ff})
                                + SlotIdxW'({2'b00, has_payload});
               job.frame_end    = (left_next == 8'd0);
               bytes_left_in    = left_next;
               frame_open_in    = !job.frame_end;
               tail_valid_in    = 1'b0;
            end
         end
         default: ;
      endcase
   end

   assign push     = accept && (job.slot_count != '0);
   assign push_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= 8'd0;
         frame_open_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else if (accept) begin
         bytes_left_ff <= bytes_left_in;
         frame_open_ff <= frame_open_in;
         tail_valid_ff <= tail_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tail_byte_ff <= tail_byte_in;
      end
   end

   // A deferred byte only exists inside an open frame.
   a_tail_in_frame: assert property (@(posedge clock) disable iff (reset)
      tail_valid_ff |-> frame_open_ff)
      else $error("deferred byte outside an open frame");

endmodule

`default_nettype wire

@@ hw/rtl/erfb_queue.sv @@
// Job queue: short FIFO between the front end and the byte emitter.
`default_nettype none

module erfb_queue #(
   parameter int DEPTH = erfb_pkg::QueueDepth
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire erfb_pkg::job_type push_job,
   output logic                  full,
   input  wire logic             pop,
   output logic                  head_valid,
   output erfb_pkg::job_type     head_job
);
   import erfb_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   job_type             mem [DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff,  count_in;
   logic                do_push;
   logic                do_pop;

   assign full       = (count_ff == CntW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(DEPTH))
      else $error("job queue overflow");

endmodule

`default_nettype wire

@@ hw/rtl/erfb_back.sv @@
// Back end: expands queued jobs into escaped bytes, one byte per cycle while rsp_stall is low.
`default_nettype none

module erfb_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             head_valid,
   input  wire erfb_pkg::job_type head_job,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output erfb_pkg::rsp_type     rsp_data
);
   import erfb_pkg::*;

   logic [SlotIdxW-1:0] idx_ff, idx_in;
   logic                phase_ff, phase_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic       can_load;
   logic       fire;
   logic [7:0] cur;
   logic       esc_now;
   logic       slot_done;
   logic       last;

   assign can_load  = !rsp_valid_ff || !rsp_stall;
   assign fire      = head_valid && can_load;
   assign cur       = head_job.slot_byte[idx_ff];
   assign esc_now   = head_job.slot_esc[idx_ff] && needs_escape(cur);
   assign slot_done = !esc_now || phase_ff;
   assign last      = slot_done && (idx_ff == head_job.slot_count - SlotIdxW'(1));
   assign pop       = fire && last;

   always_comb begin
      idx_in   = idx_ff;
      phase_in = phase_ff;
      rsp_in   = rsp_ff;
      if (fire) begin
         if (!esc_now) begin
            rsp_in.out_byte = cur;
         end else if (!phase_ff) begin
            rsp_in.out_byte = EscMark;
         end else begin
            rsp_in.out_byte = (cur == RawFf) ? EscFf : EscFe;
         end
         rsp_in.run_last  = last;
         rsp_in.frame_end = last && head_job.frame_end;
         if (!slot_done) begin
            phase_in = 1'b1;
         end else begin
            phase_in = 1'b0;
            idx_in   = last ? '0 : idx_ff + SlotIdxW'(1);
         end
      end
   end

   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (idx_ff < head_job.slot_count))
      else $error("slot index beyond job");

   a_escape_holds_job: assert property (@(posedge clock) disable iff (reset)
      (phase_ff || idx_ff != '0) |-> head_valid)
      else $error("job left the queue mid-expansion");

   a_pop_marks_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> (rsp_valid_ff && rsp_ff.run_last))
      else $error("job retired without a last byte");

endmodule

`default_nettype wire

@@ hw/rtl/escaped_radio_frame_builder_unit.sv @@
// Top level of the escaped radio frame builder.
`default_nettype none

// Byte-stuffed frame builder. A start item (opcode 0) emits the header:
// 0xFE, payload_length + 4 (mod 256), source_port and dest_port raw, then
// the destination address high and low bytes escaped (0xFF -> FE FD,
// 0xFE -> FE FC). When either address byte needs escaping, the low byte is
// held back and sent ahead of the next data item's byte. Each data item
// (opcode 1) of an open frame emits its escaped payload byte; data with no
// open frame is dropped, and a new start abandons any open frame. run_last
// marks the last byte of each item, frame_end the last byte of the frame.
// Rate: the emitter puts out one byte per cycle while rsp_stall is low. An
// item yields 1 or 2 output bytes for a data item (up to 4 with a held-back
// address byte), 5 or 6 for a start. The single output byte register sets
// this pace. The front end accepts an item each cycle while the job queue
// has room, so items keep flowing while earlier ones are still being
// expanded. The first byte passes the job queue, then the output register.
module escaped_radio_frame_builder_unit #(
   parameter int QUEUE_DEPTH = erfb_pkg::QueueDepth
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire erfb_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output erfb_pkg::rsp_type     rsp_data
);
   import erfb_pkg::*;

   // Front end to queue.
   logic    push;
   job_type push_job;
   logic    queue_full;

   // Queue to emitter.
   logic    head_valid;
   job_type head_job;
   logic    pop;

   // Classify items, keep frame state, build one job per productive item.
   erfb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   // Decouple acceptance from byte emission.
   erfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // Expand jobs into bytes; hold the output register under stall.
   erfb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

@@ tb/erfb_stream_checker.sv @@
// Checker for the frame builder: predicts the escaped byte stream and compares results.
`timescale 1ns / 100ps

module erfb_stream_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire erfb_pkg::req_type req_data,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire erfb_pkg::rsp_type rsp_data,
   output int unsigned            mismatch_count,
   output int unsigned            bytes_pending,
   output int unsigned            bytes_checked
);
   import erfb_pkg::*;

   // shadow of the encoder state
   logic [7:0] bytes_left;
   logic       frame_open;
   logic       tail_pending;
   logic [7:0] tail_byte;

   rsp_type    item_bytes[$];
   rsp_type    expected_bytes[$];

   task automatic add_byte(input logic [7:0] b);
      rsp_type r;
      r = '0;
      r.out_byte = b;
      item_bytes.push_back(r);
   endtask

   task automatic add_escaped(input logic [7:0] b);
      if (b == RawFf) begin
         add_byte(EscMark);
         add_byte(EscFf);
      end else if (b == RawFe) begin
         add_byte(EscMark);
         add_byte(EscFe);
      end else begin
         add_byte(b);
      end
   endtask

   // Expand one accepted item into the bytes it should produce.
   task automatic encode_item(input req_type it);
      logic [7:0] hi;
      logic [7:0] lo;
      logic       closes;
      rsp_type    last;
      closes = 1'b0;
      item_bytes.delete();
      if (it.opcode == OpStart) begin
         hi = it.dest_address[15:8];
         lo = it.dest_address[7:0];
         add_byte(EscMark);
         add_byte(it.payload_length + FrameLenExtra);
         add_byte(it.source_port);
         add_byte(it.dest_port);
         add_escaped(hi);
         // an escaped address byte pushes the low byte into the next data item
         tail_pending = (hi == RawFf) || (hi == RawFe) || (lo == RawFf) || (lo == RawFe);
         tail_byte    = tail_pending ? lo : 8'h00;
         if (!tail_pending)
            add_byte(lo);
         bytes_left = it.payload_length;
         frame_open = 1'b1;
         if (bytes_left == 8'd0 && !tail_pending) begin
            frame_open = 1'b0;
            closes     = 1'b1;
         end
      end else if (frame_open) begin
         if (tail_pending) begin
            add_escaped(tail_byte);
            tail_pending = 1'b0;
            tail_byte    = 8'h00;
         end
         if (bytes_left != 8'd0) begin
            add_escaped(it.payload_byte);
            bytes_left = bytes_left - 8'd1;
         end
         if (bytes_left == 8'd0) begin
            frame_open = 1'b0;
            closes     = 1'b1;
         end
      end
      if (item_bytes.size() != 0) begin
         last = item_bytes.pop_back();
         last.run_last  = 1'b1;
         last.frame_end = closes;
         item_bytes.push_back(last);
      end
      foreach (item_bytes[k])
         expected_bytes.push_back(item_bytes[k]);
   endtask

   task automatic report(input string what, input logic [7:0] want, input logic [7:0] got);
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
   endtask

   task automatic check_byte(input rsp_type got);
      rsp_type want;
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
         mismatch_count++;
         $display("%0t: unexpected result, expected none, actual %h/%b/%b",
                  $time, got.out_byte, got.run_last, got.frame_end);
      end else begin
         want = expected_bytes.pop_front();
         if (got.out_byte !== want.out_byte)
            report("out_byte", want.out_byte, got.out_byte);
         if (got.run_last !== want.run_last)
            report("run_last", 8'(want.run_last), 8'(got.run_last));
         if (got.frame_end !== want.frame_end)
            report("frame_end", 8'(want.frame_end), 8'(got.frame_end));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         bytes_left     = 8'd0;
         frame_open     = 1'b0;
         tail_pending   = 1'b0;
         tail_byte      = 8'd0;
         mismatch_count = 0;
         bytes_checked  = 0;
         expected_bytes.delete();
      end else begin
         if (req_valid && !req_stall)
            encode_item(req_data);
         if (rsp_valid && !rsp_stall)
            check_byte(rsp_data);
      end
      bytes_pending = expected_bytes.size();
   end

endmodule

@@ tb/tb_escaped_radio_frame_builder_unit.sv @@
// Testbench top for the escaped radio frame builder: stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb_escaped_radio_frame_builder_unit;
   import erfb_pkg::*;

   localparam int CycleLimit = 200000;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;

   int unsigned mismatch_count;
   int unsigned bytes_pending;
   int unsigned bytes_checked;

   // stimulus bookkeeping: stop decision, summary counts and the calm-stretch flag
   int          items_counted = 0;
   int          frames_sent   = 0;
   int          stray_data    = 0;
   int          cycle_count   = 0;
   logic        calm          = 1'b0;

   escaped_radio_frame_builder_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   erfb_stream_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .bytes_pending  (bytes_pending),
      .bytes_checked  (bytes_checked)
   );

   always #5 clock = ~clock;

   // Stall the result side at random, 29 percent of the time, except in the calm stretch.
   always @(posedge clock)
      rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 29);

   // Hand one item to the block: idle a random while first, then hold the
   // item until a clock edge takes it. Sample stall at the falling edge,
   // where it has settled to the value the next rising edge will see.
   task automatic push_item(input req_type it);
      logic taken;
      while (!calm && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data  <= it;
      req_valid <= 1'b1;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
   endtask

   // Fill unused fields with noise so the block must ignore them.
   task automatic send_start(input logic [15:0] addr, input logic [7:0] sport,
                             input logic [7:0] dport, input logic [7:0] len);
      req_type it;
      it = req_type'($bits(req_type)'({$urandom, $urandom}));
      it.opcode         = OpStart;
      it.dest_address   = addr;
      it.source_port    = sport;
      it.dest_port      = dport;
      it.payload_length = len;
      frames_sent++;
      push_item(it);
   endtask

   task automatic send_data(input logic [7:0] b);
      req_type it;
      it = req_type'($bits(req_type)'({$urandom, $urandom}));
      it.opcode       = OpData;
      it.payload_byte = b;
      push_item(it);
   endtask

   // Favor the bytes that escaping cares about.
   function automatic logic [7:0] pick_byte();
      if ($urandom_range(99) < 25)
         return 8'hFC + 8'($urandom_range(3));
      return 8'($urandom_range(255));
   endfunction

   // One frame with random content: mostly complete, sometimes cut short
   // by the next start, sometimes followed by stray data that must vanish.
   task automatic random_frame();
      logic [15:0] addr;
      logic [7:0]  len;
      logic        defer_lo;
      int          needed;
      int          sent;
      int          pick;
      addr = {pick_byte(), pick_byte()};
      pick = $urandom_range(99);
      if (pick < 80)
         len = 8'($urandom_range(6));
      else if (pick < 95)
         len = 8'($urandom_range(40, 7));
      else
         len = 8'($urandom_range(255, 241));
      defer_lo = (addr[15:8] >= RawFe) || (addr[7:0] >= RawFe);
      needed   = (len == 8'd0 && defer_lo) ? 1 : int'(len);
      sent     = needed;
      if (len > 8'd40 || $urandom_range(99) < 12)
         sent = $urandom_range(needed < 12 ? needed : 12);
      send_start(addr, pick_byte(), pick_byte(), len);
      for (int k = 0; k < sent; k++)
         send_data(pick_byte());
      items_counted += 1 + sent;
      if (sent == needed && $urandom_range(99) < 10) begin
         repeat ($urandom_range(2, 1)) begin
            send_data(pick_byte());
            stray_data++;
         end
      end
   endtask

   // Abort on a hung handshake or a lost result.
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("escaped_radio_frame_builder_unit test failed");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // data before any start: drop
      send_data(8'h55);
      // empty frame with plain address: header alone closes it
      send_start(16'h1234, 8'h00, 8'hFF, 8'd0);
      send_data(8'hAA);
      // escaped high byte: low byte rides ahead of the first data byte
      send_start(16'hFFFE, 8'hFE, 8'hFF, 8'd2);
      send_data(8'hFF);
      send_data(8'hFE);
      // empty payload with a held-back low byte: next data sends only that byte
      send_start(16'h12FF, 8'h80, 8'h01, 8'd0);
      send_data(8'h3C);
      // length byte wraps past 255
      send_start(16'hFE00, 8'h7F, 8'hFD, 8'd255);
      send_data(8'hFD);
      send_data(8'hFC);
      // new start abandons the open frame
      send_start(16'h0000, 8'hFC, 8'h00, 8'd251);
      send_data(8'h00);
      send_data(8'hFF);
      // abandon a frame while its low byte is still held back
      send_start(16'hFFFF, 8'h01, 8'h02, 8'd1);
      send_start(16'h7FFE, 8'hFF, 8'hFE, 8'd3);
      send_data(8'h01);
      send_data(8'h80);
      send_data(8'h7F);
      send_data(8'h11);
      send_start(16'hABCD, 8'h55, 8'hAA, 8'd252);
      send_start(16'h00FF, 8'h10, 8'h20, 8'd1);
      send_data(8'hFF);
      items_counted = 23;

      while (items_counted < 390) begin
         calm = (items_counted >= 150 && items_counted < 230);
         if ($urandom_range(99) < 4) begin
            send_data(pick_byte());
            stray_data++;
         end
         random_frame();
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      // drain, then let any late extra byte show up
      while (bytes_pending != 0)
         @(negedge clock);
      repeat (20) @(posedge clock);
      @(negedge clock);

      $display("Sent %0d counted items in %0d frames, plus %0d stray data items.",
               items_counted, frames_sent, stray_data);
      $display("Checked %0d result bytes, %0d mismatches.", bytes_checked, mismatch_count);
      if (mismatch_count == 0 && bytes_pending == 0)
         $display("escaped_radio_frame_builder_unit test passed");
      else
         $display("escaped_radio_frame_builder_unit test failed");
      $finish;
   end

endmodule
